>>> rtl/assert_macros.svh
// Assertion macros for the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define TGARR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define TGARR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/tgarr_pkg.sv
// Types, constants and helpers for the two-group round-robin scheduler.
package tgarr_pkg;

  localparam int SLOTS_PER_GROUP = 10;
  localparam int NUM_SLOTS       = 2 * SLOTS_PER_GROUP;
  localparam int OFF_W           = $clog2(SLOTS_PER_GROUP);
  localparam int SLOT_W          = $clog2(NUM_SLOTS);

  localparam int IDX_W    = 13;
  localparam int BUDGET_W = 5;
  localparam int CFG_W    = 13;
  localparam int CFG_A_W  = 2;

  localparam logic [BUDGET_W-1:0] BUDGET_RESET = BUDGET_W'(20);

  // Opcodes
  localparam logic [1:0] OP_NEXT  = 2'd0;
  localparam logic [1:0] OP_KILL  = 2'd1;
  localparam logic [1:0] OP_SPAWN = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_A_W-1:0] REG_TASK_BASE = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_IDLE_IDX  = 2'd1;
  localparam logic [CFG_A_W-1:0] REG_BUDGET    = 2'd2;

  typedef struct packed {
    logic [1:0] opcode;
    logic       spawn_group;
  } in_t;

  typedef struct packed {
    logic [15:0] task_selector;
    logic        went_idle;
    logic        spawn_done;
    logic [4:0]  spawn_slot;
  } out_t;

  typedef struct packed {
    logic             start;
    logic             grp;
    logic [OFF_W-1:0] off;
    logic             want_alive;
  } scan_cmd_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic              found;
    logic [OFF_W-1:0]  off;
    logic [SLOT_W-1:0] slot;
  } scan_res_t;

  // Next offset in a group, wrapping at the group size.
  function automatic logic [OFF_W-1:0] off_inc(input logic [OFF_W-1:0] off);
    logic [OFF_W-1:0] r;
    if (off == OFF_W'(SLOTS_PER_GROUP - 1)) r = '0;
    else r = off + 1'b1;
    return r;
  endfunction

endpackage

>>> rtl/tgarr_scan.sv
// Shared slot scanner: tests one slot of a group per cycle in round-robin order.
module tgarr_scan (
  input  logic                             clk,
  input  logic                             rst_n,
  input  tgarr_pkg::scan_cmd_t             cmd,
  input  logic [tgarr_pkg::NUM_SLOTS-1:0]  alive,
  output tgarr_pkg::scan_res_t             res
);
  import tgarr_pkg::*;

  logic             busy_r;
  logic             grp_r;
  logic             want_r;
  logic [OFF_W-1:0] off_r;
  logic [OFF_W-1:0] cnt_r;

  logic [SLOT_W-1:0] slot;
  logic              hit;
  logic              last;

  assign slot = grp_r ? (SLOT_W'(SLOTS_PER_GROUP) + SLOT_W'(off_r)) : SLOT_W'(off_r);
  assign hit  = (alive[slot] == want_r);
  assign last = (cnt_r == OFF_W'(SLOTS_PER_GROUP - 1));

  assign res.busy  = busy_r;
  assign res.done  = busy_r && (hit || last);
  assign res.found = busy_r && hit;
  assign res.off   = off_r;
  assign res.slot  = slot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (cmd.start) begin
      busy_r <= 1'b1;
    end else if (res.done) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      grp_r  <= cmd.grp;
      want_r <= cmd.want_alive;
      off_r  <= cmd.off;
      cnt_r  <= '0;
    end else if (busy_r) begin
      off_r <= off_inc(off_r);
      cnt_r <= cnt_r + 1'b1;
    end
  end

endmodule

>>> rtl/two_group_alternating_round_robin.sv
// Two-group round-robin task scheduler: sequencer, slot state and result register.
//
// Items arrive on in_valid/in_ready/in_data and results leave on
// out_valid/out_ready/out_data, one result per item. An item is taken when
// valid and ready are both high at a rising edge of clk.
// NEXT walks the opposite group from its last pick, then the current group,
// one slot per cycle in the shared scanner; SPAWN walks its group from slot
// zero for the lowest free slot; KILL and the unused opcode need no walk.
// KILL, the unused opcode and a SPAWN with no budget go straight to the
// finish state; a SPAWN walks at most one group and a NEXT at most both
// groups (ten slots each) before their results are ready. One item is in
// work at a time, and the block takes no new item until the last one's
// result has gone to the output register; in_ready is high while the
// sequencer waits for an item.
// A finished result sits in the output register; the next item may be taken
// while it waits, and if the receiver still stalls when that item finishes,
// the sequencer holds its result until the register frees.
// Reset (rst_n low at a clock edge) clears all alive bits, the last picks and
// the current slot, reloads both budgets with 20 and zeroes both indexes.
// cfg_we writes cfg_wdata to register cfg_idx at once; a budget write also
// reloads both groups' budgets.
module two_group_alternating_round_robin (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  tgarr_pkg::in_t                   in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output tgarr_pkg::out_t                  out_data,
  input  logic                             cfg_we,
  input  logic [tgarr_pkg::CFG_A_W-1:0]    cfg_idx,
  input  logic [tgarr_pkg::CFG_W-1:0]      cfg_wdata
);
  import tgarr_pkg::*;
  `include "assert_macros.svh"

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_SCAN_OPP = 3'd1;
  localparam logic [2:0] ST_SCAN_CUR = 3'd2;
  localparam logic [2:0] ST_SCAN_FREE = 3'd3;
  localparam logic [2:0] ST_FIN      = 3'd4;

  logic [2:0]           state_r, state_nxt;
  logic [NUM_SLOTS-1:0] alive_r, alive_nxt;
  logic [OFF_W-1:0]     last_pick_r [2];
  logic [OFF_W-1:0]     last_pick_nxt [2];
  logic [SLOT_W-1:0]    cur_slot_r, cur_slot_nxt;
  logic [BUDGET_W-1:0]  budget_r [2];
  logic [BUDGET_W-1:0]  budget_nxt [2];
  logic [IDX_W-1:0]     base_r, base_nxt;
  logic [IDX_W-1:0]     idle_idx_r, idle_idx_nxt;
  logic                 grp_r, grp_nxt;
  out_t                 res_r, res_nxt;
  out_t                 out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;

  scan_cmd_t scan_cmd;
  scan_res_t scan_res;

  logic cur_grp;
  logic opp_grp;

  tgarr_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (scan_cmd),
    .alive (alive_r),
    .res   (scan_res)
  );

  assign cur_grp   = (cur_slot_r >= SLOT_W'(SLOTS_PER_GROUP));
  assign opp_grp   = ~cur_grp;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    alive_nxt     = alive_r;
    last_pick_nxt = last_pick_r;
    cur_slot_nxt  = cur_slot_r;
    budget_nxt    = budget_r;
    base_nxt      = base_r;
    idle_idx_nxt  = idle_idx_r;
    grp_nxt       = grp_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    scan_cmd      = '0;

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_we) begin
      case (cfg_idx)
        REG_TASK_BASE: base_nxt = cfg_wdata;
        REG_IDLE_IDX:  idle_idx_nxt = cfg_wdata;
        REG_BUDGET: begin
          budget_nxt[0] = cfg_wdata[BUDGET_W-1:0];
          budget_nxt[1] = cfg_wdata[BUDGET_W-1:0];
        end
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          res_nxt = '0;
          case (in_data.opcode)
            OP_NEXT: begin
              scan_cmd.start      = 1'b1;
              scan_cmd.grp        = opp_grp;
              scan_cmd.off        = off_inc(last_pick_r[opp_grp]);
              scan_cmd.want_alive = 1'b1;
              state_nxt           = ST_SCAN_OPP;
            end
            OP_KILL: begin
              alive_nxt[cur_slot_r] = 1'b0;
              state_nxt             = ST_FIN;
            end
            OP_SPAWN: begin
              grp_nxt = in_data.spawn_group;
              if (budget_r[in_data.spawn_group] != '0) begin
                scan_cmd.start      = 1'b1;
                scan_cmd.grp        = in_data.spawn_group;
                scan_cmd.off        = '0;
                scan_cmd.want_alive = 1'b0;
                state_nxt           = ST_SCAN_FREE;
              end else begin
                state_nxt = ST_FIN;
              end
            end
            default: state_nxt = ST_FIN;
          endcase
        end
      end
      ST_SCAN_OPP, ST_SCAN_CUR: begin
        if (scan_res.done) begin
          if (scan_res.found) begin
            cur_slot_nxt = scan_res.slot;
            if (state_r == ST_SCAN_OPP) last_pick_nxt[opp_grp] = scan_res.off;
            else last_pick_nxt[cur_grp] = scan_res.off;
            res_nxt.task_selector = {base_r + IDX_W'(scan_res.slot), 3'b011};
            state_nxt             = ST_FIN;
          end else if (state_r == ST_SCAN_OPP) begin
            // fall back to the current group
            scan_cmd.start      = 1'b1;
            scan_cmd.grp        = cur_grp;
            scan_cmd.off        = off_inc(last_pick_r[cur_grp]);
            scan_cmd.want_alive = 1'b1;
            state_nxt           = ST_SCAN_CUR;
          end else begin
            res_nxt.task_selector = {idle_idx_r, 3'b000};
            res_nxt.went_idle     = 1'b1;
            state_nxt             = ST_FIN;
          end
        end
      end
      ST_SCAN_FREE: begin
        if (scan_res.done) begin
          if (scan_res.found) begin
            alive_nxt[scan_res.slot] = 1'b1;
            budget_nxt[grp_r]        = budget_r[grp_r] - 1'b1;
            res_nxt.spawn_done       = 1'b1;
            res_nxt.spawn_slot       = 5'(scan_res.slot);
          end
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // hand over once the output register is free
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      alive_r        <= '0;
      last_pick_r[0] <= '0;
      last_pick_r[1] <= '0;
      cur_slot_r     <= '0;
      budget_r[0]    <= BUDGET_RESET;
      budget_r[1]    <= BUDGET_RESET;
      base_r         <= '0;
      idle_idx_r     <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      alive_r     <= alive_nxt;
      last_pick_r <= last_pick_nxt;
      cur_slot_r  <= cur_slot_nxt;
      budget_r    <= budget_nxt;
      base_r      <= base_nxt;
      idle_idx_r  <= idle_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    grp_r <= grp_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  `TGARR_ASSERT(a_scan_only_in_scan_states, clk, rst_n, ((state_r == ST_IDLE || state_r == ST_FIN) |-> !scan_res.busy), "scanner busy outside a scan state")
  `TGARR_ASSERT(a_spawn_marks_alive, clk, rst_n, ((state_r == ST_SCAN_FREE && scan_res.found) |=> alive_r[$past(scan_res.slot)]), "spawned slot not marked alive")
  `TGARR_ASSERT(a_idle_result_clean, clk, rst_n, ((out_valid && out_data.went_idle) |-> (out_data.task_selector[2:0] == 3'b000 && !out_data.spawn_done)), "idle result carries task fields")
  `TGARR_ASSERT_ALWAYS(a_no_out_after_reset, clk, ($past(!rst_n) |-> !out_valid), "result valid straight after reset")

endmodule
